// ----- hw/rtl/wfst_pkg.sv -----
// ----------------------------------------------------------------------------
// Warm frame state table package
// Word formats, action and transition codes, and the cell interface types.
// ----------------------------------------------------------------------------
package wfst_pkg;

    localparam int LIST_CAP = 32;
    localparam int CNT_W    = $clog2(LIST_CAP + 1);

    typedef enum logic [3:0] {
        ACT_GEN_NOTE    = 4'd0,
        ACT_SKIP        = 4'd1,
        ACT_COMPLETE    = 4'd2,
        ACT_EVICT       = 4'd3,
        ACT_DIRTY       = 4'd4,
        ACT_TRANSITION  = 4'd5,
        ACT_RESET_OWNER = 4'd6,
        ACT_QUERY       = 4'd7,
        ACT_READ_GEN    = 4'd8,
        ACT_LIST        = 4'd9
    } action_e;

    typedef enum logic [2:0] {
        KIND_QUEUED   = 3'd0,
        KIND_RUNNING  = 3'd1,
        KIND_FINISHED = 3'd2,
        KIND_CANCELED = 3'd3,
        KIND_SHED     = 3'd4,
        KIND_SHUTDOWN = 3'd5,
        KIND_STALE    = 3'd6,
        KIND_NONE     = 3'd7
    } kind_e;

    typedef enum logic [1:0] {
        OUTC_PUBLISHED = 2'd0,
        OUTC_DECLINED  = 2'd1,
        OUTC_OTHER     = 2'd2,
        OUTC_SPARE     = 2'd3
    } outcome_e;

    typedef enum logic [1:0] {
        FS_UNCACHED = 2'd0,
        FS_WARMING  = 2'd1,
        FS_DIRTY    = 2'd2,
        FS_CACHED   = 2'd3
    } frame_state_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } ctrl_state_e;

    typedef struct packed {
        logic [3:0]  action;
        logic [3:0]  owner_id;
        logic [63:0] time_bits;
        logic [31:0] gen_value;
        logic [63:0] epoch_digest;
        logic [63:0] key_tag;
        logic [2:0]  transition_kind;
        logic [1:0]  outcome;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  frame_state;
        logic        unwarmable;
        logic        visitable;
        logic        key_found;
        logic        cached_key_found;
        logic [63:0] key_tag_out;
        logic [63:0] key_digest_out;
        logic [63:0] time_out;
        logic [31:0] gen_out;
        logic        item_valid;
        logic        table_full;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic     shift;
        in_word_t cmd;
    } cell_ctl_t;

    typedef struct packed {
        logic        hit;
        logic        free;
        logic        listable;
        logic [7:0]  streak;
        logic        completed;
        logic        dirty;
        logic        queued;
        logic [7:0]  running;
        logic [31:0] done_gen;
        logic [63:0] key_tag;
        logic [63:0] key_digest;
        logic [63:0] time_bits;
    } cell_stat_t;

endpackage

// ----- hw/rtl/wfst_cell.sv -----
// ----------------------------------------------------------------------------
// Warm frame state table cell
// Holds one frame record and passes the sweep token to its neighbor.
// ----------------------------------------------------------------------------
module wfst_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tok_in,
    output logic                tok_out,
    input  wfst_pkg::cell_ctl_t ctl,
    input  logic                wr_sel,
    input  logic                wr_alloc,
    output wfst_pkg::cell_stat_t stat
);
    import wfst_pkg::*;

    logic        tok_reg, tok_next;
    logic        used_reg, used_next;
    logic [3:0]  owner_reg, owner_next;
    logic [63:0] time_reg, time_next;
    logic [7:0]  streak_reg, streak_next;
    logic        completed_reg, completed_next;
    logic [63:0] tag_reg, tag_next;
    logic [63:0] dig_reg, dig_next;
    logic [31:0] gen_reg, gen_next;
    logic        dirty_reg, dirty_next;
    logic        queued_reg, queued_next;
    logic [7:0]  running_reg, running_next;

    logic        own_match;
    logic [7:0]  b_streak, b_running;
    logic        b_completed, b_dirty, b_queued;
    logic [63:0] b_tag, b_dig;
    logic [31:0] b_gen;
    logic [7:0]  streak_inc, running_inc, running_dec;

    assign own_match = owner_reg == ctl.cmd.owner_id;
    assign tok_out   = tok_reg;

    always_comb
    begin
        stat = '0;
        if (tok_reg)
        begin
            stat.hit        = used_reg && own_match && (time_reg == ctl.cmd.time_bits);
            stat.free       = !used_reg;
            stat.listable   = used_reg && own_match && completed_reg;
            stat.streak     = streak_reg;
            stat.completed  = completed_reg;
            stat.dirty      = dirty_reg;
            stat.queued     = queued_reg;
            stat.running    = running_reg;
            stat.done_gen   = gen_reg;
            stat.key_tag    = tag_reg;
            stat.key_digest = dig_reg;
            stat.time_bits  = time_reg;
        end
    end

    always_comb
    begin
        b_streak    = wr_alloc ? 8'd0 : streak_reg;
        b_running   = wr_alloc ? 8'd0 : running_reg;
        b_completed = wr_alloc ? 1'b0 : completed_reg;
        b_dirty     = wr_alloc ? 1'b0 : dirty_reg;
        b_queued    = wr_alloc ? 1'b0 : queued_reg;
        b_tag       = wr_alloc ? 64'd0 : tag_reg;
        b_dig       = wr_alloc ? 64'd0 : dig_reg;
        b_gen       = wr_alloc ? 32'd0 : gen_reg;
        streak_inc  = (b_streak != 8'hFF) ? b_streak + 8'd1 : b_streak;
        running_inc = (b_running != 8'hFF) ? b_running + 8'd1 : b_running;
        running_dec = (b_running != 8'd0) ? b_running - 8'd1 : b_running;

        tok_next       = ctl.shift ? tok_in : tok_reg;
        used_next      = used_reg;
        owner_next     = owner_reg;
        time_next      = time_reg;
        streak_next    = streak_reg;
        completed_next = completed_reg;
        tag_next       = tag_reg;
        dig_next       = dig_reg;
        gen_next       = gen_reg;
        dirty_next     = dirty_reg;
        queued_next    = queued_reg;
        running_next   = running_reg;

        if (wr_sel)
        begin
            used_next      = 1'b1;
            if (wr_alloc)
            begin
                owner_next = ctl.cmd.owner_id;
                time_next  = ctl.cmd.time_bits;
            end
            streak_next    = b_streak;
            completed_next = b_completed;
            tag_next       = b_tag;
            dig_next       = b_dig;
            gen_next       = b_gen;
            dirty_next     = b_dirty;
            queued_next    = b_queued;
            running_next   = b_running;
            case (ctl.cmd.action)
                ACT_SKIP:
                begin
                    streak_next = streak_inc;
                end
                ACT_COMPLETE:
                begin
                    completed_next = 1'b1;
                    tag_next       = ctl.cmd.key_tag;
                    dig_next       = ctl.cmd.epoch_digest;
                    gen_next       = ctl.cmd.gen_value;
                    dirty_next     = 1'b0;
                    streak_next    = 8'd0;
                end
                ACT_EVICT:
                begin
                    if (b_completed && (b_tag == ctl.cmd.key_tag)
                        && (b_dig == ctl.cmd.epoch_digest))
                    begin
                        completed_next = 1'b0;
                        streak_next    = 8'd0;
                        dirty_next     = 1'b0;
                    end
                end
                ACT_DIRTY:
                begin
                    if (b_completed)
                    begin
                        dirty_next = 1'b1;
                    end
                end
                ACT_TRANSITION:
                begin
                    case (ctl.cmd.transition_kind)
                        KIND_QUEUED:
                        begin
                            queued_next = 1'b1;
                        end
                        KIND_RUNNING:
                        begin
                            queued_next  = 1'b0;
                            running_next = running_inc;
                        end
                        KIND_FINISHED:
                        begin
                            queued_next  = 1'b0;
                            running_next = running_dec;
                            if (ctl.cmd.outcome == OUTC_PUBLISHED)
                            begin
                                streak_next = 8'd0;
                            end
                            else if (ctl.cmd.outcome == OUTC_DECLINED)
                            begin
                                streak_next = streak_inc;
                            end
                        end
                        KIND_CANCELED, KIND_SHED, KIND_SHUTDOWN:
                        begin
                            queued_next = 1'b0;
                        end
                        KIND_STALE:
                        begin
                            running_next = running_dec;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
        else if (tok_reg && ctl.shift && used_reg && own_match)
        begin
            if (ctl.cmd.action == ACT_GEN_NOTE)
            begin
                streak_next = 8'd0;
            end
            else if (ctl.cmd.action == ACT_RESET_OWNER)
            begin
                used_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg  <= 1'b0;
            used_reg <= 1'b0;
        end
        else
        begin
            tok_reg  <= tok_next;
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        owner_reg     <= owner_next;
        time_reg      <= time_next;
        streak_reg    <= streak_next;
        completed_reg <= completed_next;
        tag_reg       <= tag_next;
        dig_reg       <= dig_next;
        gen_reg       <= gen_next;
        dirty_reg     <= dirty_next;
        queued_reg    <= queued_next;
        running_reg   <= running_next;
    end

endmodule

// ----- hw/rtl/warm_frame_state_table_unit.sv -----
// ----------------------------------------------------------------------------
// Warm frame state table unit
// Frame record table built as a chain of record cells swept by a token.
// ----------------------------------------------------------------------------
// Every input word takes one sweep of the cell chain, one cell per cycle
// while the sweep is not paused, and a new word is taken only after the
// sweep ends and its closing result word is issued; a listing that finds
// several records pauses the sweep while a result word waits to be taken.
// The owner generation store is cleared at reset through per-owner valid
// bits, so no clearing pass is needed.
module warm_frame_state_table_unit #(
    parameter int ENTRIES = 32,
    parameter int OWNERS  = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  wfst_pkg::in_word_t   in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output wfst_pkg::out_word_t  out_word,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_data
);
    import wfst_pkg::*;

    localparam int IW  = $clog2(ENTRIES);
    localparam int OIW = (OWNERS > 1) ? $clog2(OWNERS) : 1;

    ctrl_state_e state_reg, state_next;

    in_word_t    cmd_reg, cmd_next;
    logic [7:0]  thr_reg;
    logic [IW-1:0] idx_reg, idx_next;
    logic        found_reg, found_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic        free_reg, free_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    cell_stat_t  hit_rec_reg, hit_rec_next;
    logic        pend_reg, pend_next;
    cell_stat_t  pend_rec_reg, pend_rec_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_word_reg, out_word_next;

    logic [31:0] gen_mem [OWNERS];
    logic [OWNERS-1:0] gen_vld_reg;
    logic [31:0] gen_rd_reg;
    logic        gen_hit_reg;
    logic        in_range_reg;
    logic [OIW+3:0] owner_wide;
    logic [OIW-1:0] gen_addr;
    logic [OIW+3:0] cmd_owner_wide;
    logic [OIW-1:0] cmd_addr;
    logic        gen_wr;

    logic        start;
    logic        adv;
    logic        out_free;
    logic        need_rec;
    logic        wr_en;
    logic        wr_alloc;
    logic [IW-1:0] wr_idx;
    logic [31:0] cur_gen;
    logic [1:0]  q_state;
    logic        q_unw;
    logic        list_take;

    cell_ctl_t   ctl;
    cell_stat_t  stat [ENTRIES];
    cell_stat_t  stat_or;
    logic [ENTRIES-1:0] tok;

    assign in_ready  = state_reg == ST_IDLE;
    assign start     = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign owner_wide     = (OIW + 4)'(in_word.owner_id);
    assign gen_addr       = owner_wide[OIW-1:0];
    assign cmd_owner_wide = (OIW + 4)'(cmd_reg.owner_id);
    assign cmd_addr       = cmd_owner_wide[OIW-1:0];

    always_comb
    begin
        stat_or = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            stat_or = stat_or | stat[i];
        end
    end

    assign list_take = (cmd_reg.action == ACT_LIST) && stat_or.listable
                       && (cnt_reg < CNT_W'(LIST_CAP));
    assign adv       = !(list_take && pend_reg && !out_free);

    assign need_rec = (cmd_reg.action == ACT_SKIP) || (cmd_reg.action == ACT_COMPLETE)
                      || ((cmd_reg.action == ACT_TRANSITION)
                          && (cmd_reg.transition_kind != KIND_NONE));
    assign cur_gen  = gen_hit_reg ? gen_rd_reg : 32'd0;

    assign ctl.shift = start || ((state_reg == ST_SCAN) && adv);
    assign ctl.cmd   = cmd_reg;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            wfst_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .tok_in   ((g == 0) ? start : tok[(g == 0) ? 0 : g - 1]),
                .tok_out  (tok[g]),
                .ctl      (ctl),
                .wr_sel   (wr_en && (wr_idx == IW'(g))),
                .wr_alloc (wr_alloc),
                .stat     (stat[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (adv && (idx_reg == IW'(ENTRIES - 1)))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_state = FS_UNCACHED;
        if (found_reg)
        begin
            if (hit_rec_reg.queued || (hit_rec_reg.running != 8'd0))
            begin
                q_state = FS_WARMING;
            end
            else if (!hit_rec_reg.completed)
            begin
                q_state = FS_UNCACHED;
            end
            else if (hit_rec_reg.dirty || (hit_rec_reg.done_gen != cmd_reg.gen_value)
                     || (hit_rec_reg.key_digest != cmd_reg.epoch_digest))
            begin
                q_state = FS_DIRTY;
            end
            else
            begin
                q_state = FS_CACHED;
            end
        end
        q_unw = found_reg && (hit_rec_reg.streak >= thr_reg);
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        hit_idx_next   = hit_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        hit_rec_next   = hit_rec_reg;
        pend_next      = pend_reg;
        pend_rec_next  = pend_rec_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;
        wr_en          = 1'b0;
        wr_alloc       = 1'b0;
        wr_idx         = hit_idx_reg;
        gen_wr         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next     = in_word;
                    idx_next     = '0;
                    found_next   = 1'b0;
                    free_next    = 1'b0;
                    hit_rec_next = '0;
                    pend_next    = 1'b0;
                    cnt_next     = '0;
                end
            end
            ST_SCAN:
            begin
                if (adv)
                begin
                    idx_next = idx_reg + IW'(1);
                    if (stat_or.hit && !found_reg)
                    begin
                        found_next   = 1'b1;
                        hit_idx_next = idx_reg;
                        hit_rec_next = stat_or;
                    end
                    if (stat_or.free && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = idx_reg;
                    end
                    if (list_take)
                    begin
                        if (pend_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_word_next                = '0;
                            out_word_next.key_tag_out    = pend_rec_reg.key_tag;
                            out_word_next.key_digest_out = pend_rec_reg.key_digest;
                            out_word_next.time_out       = pend_rec_reg.time_bits;
                            out_word_next.gen_out        = cur_gen;
                            out_word_next.item_valid     = 1'b1;
                        end
                        pend_next     = 1'b1;
                        pend_rec_next = stat_or;
                        cnt_next      = cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_word_next         = '0;
                    out_word_next.gen_out = cur_gen;
                    out_word_next.last    = 1'b1;
                    if (need_rec)
                    begin
                        if (found_reg || free_reg)
                        begin
                            wr_en    = 1'b1;
                            wr_alloc = !found_reg;
                            wr_idx   = found_reg ? hit_idx_reg : free_idx_reg;
                        end
                        else
                        begin
                            out_word_next.table_full = 1'b1;
                        end
                    end
                    else
                    begin
                        case (cmd_reg.action)
                            ACT_GEN_NOTE:
                            begin
                                if (in_range_reg)
                                begin
                                    gen_wr                = 1'b1;
                                    out_word_next.gen_out = cmd_reg.gen_value;
                                end
                            end
                            ACT_EVICT, ACT_DIRTY:
                            begin
                                wr_en = found_reg;
                            end
                            ACT_QUERY:
                            begin
                                out_word_next.frame_state = q_state;
                                out_word_next.unwarmable  = q_unw;
                                out_word_next.visitable   = !q_unw && (q_state != FS_CACHED);
                                if (found_reg && hit_rec_reg.completed)
                                begin
                                    out_word_next.key_found      = 1'b1;
                                    out_word_next.key_tag_out    = hit_rec_reg.key_tag;
                                    out_word_next.key_digest_out = hit_rec_reg.key_digest;
                                    out_word_next.cached_key_found = !hit_rec_reg.dirty
                                        && (hit_rec_reg.done_gen == cmd_reg.gen_value)
                                        && (hit_rec_reg.key_digest == cmd_reg.epoch_digest);
                                end
                            end
                            ACT_LIST:
                            begin
                                if (pend_reg)
                                begin
                                    out_word_next.key_tag_out    = pend_rec_reg.key_tag;
                                    out_word_next.key_digest_out = pend_rec_reg.key_digest;
                                    out_word_next.time_out       = pend_rec_reg.time_bits;
                                    out_word_next.item_valid     = 1'b1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            thr_reg       <= 8'd3;
            gen_vld_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end
            if (gen_wr)
            begin
                gen_vld_reg[cmd_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        found_reg    <= found_next;
        hit_idx_reg  <= hit_idx_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        hit_rec_reg  <= hit_rec_next;
        pend_reg     <= pend_next;
        pend_rec_reg <= pend_rec_next;
        cnt_reg      <= cnt_next;
        out_word_reg <= out_word_next;
        if (start)
        begin
            gen_rd_reg   <= gen_mem[gen_addr];
            gen_hit_reg  <= gen_vld_reg[gen_addr] && (32'(in_word.owner_id) < OWNERS);
            in_range_reg <= 32'(in_word.owner_id) < OWNERS;
        end
        if (gen_wr)
        begin
            gen_mem[cmd_addr] <= cmd_reg.gen_value;
        end
    end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// Warm frame state table testbench
// Drives action words into the unit through valid/ready handshakes and sends
// each accepted word through a behavioral table of frame records. Every
// result word the unit returns is compared with the oldest predicted word.
// Directed tests cover the special cases. Random tests follow, with random
// idling on both sides and several threshold settings.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import wfst_pkg::*;

    localparam int ENTRIES = 32;
    localparam int OWNERS  = 16;
    localparam int SETTLE  = ENTRIES + 8;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_word_t  in_word = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_word;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [7:0] cfg_data = 8'd0;

    logic calm = 1'b0;
    int   errors = 0;

    // Behavioral copy of the record table.
    bit          rec_used [ENTRIES];
    logic [3:0]  rec_owner [ENTRIES];
    logic [63:0] rec_time [ENTRIES];
    logic [7:0]  rec_streak [ENTRIES];
    bit          rec_completed [ENTRIES];
    logic [63:0] rec_tag [ENTRIES];
    logic [63:0] rec_digest [ENTRIES];
    logic [31:0] rec_gen [ENTRIES];
    bit          rec_dirty [ENTRIES];
    bit          rec_queued [ENTRIES];
    logic [7:0]  rec_running [ENTRIES];
    logic [31:0] noted_gen [OWNERS];
    logic [7:0]  unwarm_limit = 8'd3;

    out_word_t expected_words [$];

    logic [63:0] time_pool [6];
    logic [63:0] digest_pool [3];
    logic [63:0] tag_pool [3];
    logic [31:0] gen_pool [2];

    warm_frame_state_table_unit #(.ENTRIES(ENTRIES), .OWNERS(OWNERS)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int find_record(logic [3:0] owner, logic [63:0] t);
        for (int i = 0; i < ENTRIES; i++)
            if (rec_used[i] && rec_owner[i] == owner && rec_time[i] == t)
                return i;
        return -1;
    endfunction

    function automatic int claim_record(logic [3:0] owner, logic [63:0] t);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (!rec_used[i])
            begin
                rec_used[i] = 1'b1;
                rec_owner[i] = owner;
                rec_time[i] = t;
                rec_streak[i] = '0;
                rec_completed[i] = 1'b0;
                rec_tag[i] = '0;
                rec_digest[i] = '0;
                rec_gen[i] = '0;
                rec_dirty[i] = 1'b0;
                rec_queued[i] = 1'b0;
                rec_running[i] = '0;
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void expect_word(out_word_t r);
        expected_words.insert(expected_words.size(), r);
    endfunction

    task automatic predict_frame_words(in_word_t w);
        out_word_t r;
        int s;
        int count;
        bit unw;
        r = '0;
        r.gen_out = (int'(w.owner_id) < OWNERS) ? noted_gen[w.owner_id] : '0;
        r.last = 1'b1;
        if (w.action == ACT_SKIP || w.action == ACT_COMPLETE ||
            (w.action == ACT_TRANSITION && w.transition_kind != KIND_NONE))
        begin
            s = find_record(w.owner_id, w.time_bits);
            if (s < 0)
                s = claim_record(w.owner_id, w.time_bits);
            if (s < 0)
                r.table_full = 1'b1;
            else if (w.action == ACT_SKIP)
            begin
                if (rec_streak[s] != 8'hFF) rec_streak[s]++;
            end
            else if (w.action == ACT_COMPLETE)
            begin
                rec_completed[s] = 1'b1;
                rec_tag[s] = w.key_tag;
                rec_digest[s] = w.epoch_digest;
                rec_gen[s] = w.gen_value;
                rec_dirty[s] = 1'b0;
                rec_streak[s] = '0;
            end
            else
            begin
                case (w.transition_kind)
                    KIND_QUEUED: rec_queued[s] = 1'b1;
                    KIND_RUNNING:
                    begin
                        rec_queued[s] = 1'b0;
                        if (rec_running[s] != 8'hFF) rec_running[s]++;
                    end
                    KIND_FINISHED:
                    begin
                        rec_queued[s] = 1'b0;
                        if (rec_running[s] != 0) rec_running[s]--;
                        if (w.outcome == OUTC_PUBLISHED)
                            rec_streak[s] = '0;
                        else if (w.outcome == OUTC_DECLINED && rec_streak[s] != 8'hFF)
                            rec_streak[s]++;
                    end
                    KIND_STALE:
                        if (rec_running[s] != 0) rec_running[s]--;
                    default: rec_queued[s] = 1'b0;
                endcase
            end
            expect_word(r);
            return;
        end
        case (w.action)
            ACT_GEN_NOTE:
            begin
                if (int'(w.owner_id) < OWNERS)
                begin
                    noted_gen[w.owner_id] = w.gen_value;
                    r.gen_out = w.gen_value;
                end
                for (int i = 0; i < ENTRIES; i++)
                    if (rec_used[i] && rec_owner[i] == w.owner_id)
                        rec_streak[i] = '0;
            end
            ACT_EVICT:
            begin
                s = find_record(w.owner_id, w.time_bits);
                if (s >= 0 && rec_completed[s] && rec_tag[s] == w.key_tag &&
                    rec_digest[s] == w.epoch_digest)
                begin
                    rec_completed[s] = 1'b0;
                    rec_streak[s] = '0;
                    rec_dirty[s] = 1'b0;
                end
            end
            ACT_DIRTY:
            begin
                s = find_record(w.owner_id, w.time_bits);
                if (s >= 0 && rec_completed[s])
                    rec_dirty[s] = 1'b1;
            end
            ACT_RESET_OWNER:
                for (int i = 0; i < ENTRIES; i++)
                    if (rec_used[i] && rec_owner[i] == w.owner_id)
                        rec_used[i] = 1'b0;
            ACT_QUERY:
            begin
                s = find_record(w.owner_id, w.time_bits);
                if (s < 0)
                    r.frame_state = FS_UNCACHED;
                else if (rec_queued[s] || rec_running[s] != 0)
                    r.frame_state = FS_WARMING;
                else if (!rec_completed[s])
                    r.frame_state = FS_UNCACHED;
                else if (rec_dirty[s] || rec_gen[s] != w.gen_value ||
                         rec_digest[s] != w.epoch_digest)
                    r.frame_state = FS_DIRTY;
                else
                    r.frame_state = FS_CACHED;
                unw = (s >= 0) && (rec_streak[s] >= unwarm_limit);
                r.unwarmable = unw;
                r.visitable = !unw && r.frame_state != FS_CACHED;
                if (s >= 0 && rec_completed[s])
                begin
                    r.key_found = 1'b1;
                    r.key_tag_out = rec_tag[s];
                    r.key_digest_out = rec_digest[s];
                    r.cached_key_found = !rec_dirty[s] && rec_gen[s] == w.gen_value &&
                                         rec_digest[s] == w.epoch_digest;
                end
            end
            ACT_LIST:
            begin
                count = 0;
                for (int i = 0; i < ENTRIES && count < LIST_CAP; i++)
                begin
                    if (rec_used[i] && rec_owner[i] == w.owner_id && rec_completed[i])
                    begin
                        r.key_tag_out = rec_tag[i];
                        r.key_digest_out = rec_digest[i];
                        r.time_out = rec_time[i];
                        r.item_valid = 1'b1;
                        r.last = 1'b0;
                        expect_word(r);
                        count++;
                    end
                end
                if (count == 0)
                    expect_word(r);
                else
                    expected_words[$].last = 1'b1;
                return;
            end
            default: ;
        endcase
        expect_word(r);
    endtask

    always @(posedge clk)
    begin
        if (!calm)
            out_ready <= ($urandom_range(99) >= 17);
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected result word %h", out_word);
            end
            else
            begin
                want = expected_words.pop_front();
                if (out_word !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("Mismatch: expected %h, actual %h", want, out_word);
                end
            end
        end
    end

    task automatic send_word(in_word_t w);
        if (!calm && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 17);
        end
        in_valid <= 1'b1;
        in_word <= w;
        do
            @(posedge clk);
        while (!in_ready);
        predict_frame_words(w);
    endtask

    task automatic drain();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while (expected_words.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_threshold(logic [7:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        unwarm_limit = v;
    endtask

    function automatic in_word_t make_word(logic [3:0] act, logic [3:0] owner,
                                           logic [63:0] t);
        in_word_t w;
        w = '0;
        w.action = act;
        w.owner_id = owner;
        w.time_bits = t;
        return w;
    endfunction

    task automatic test_directed();
        in_word_t w;
        send_word(make_word(ACT_QUERY, 4'd0, 64'd0));
        send_word(make_word(ACT_READ_GEN, 4'd15, '1));
        send_word(make_word(ACT_LIST, 4'd2, 64'd0));
        w = make_word(ACT_GEN_NOTE, 4'd15, 64'd0);
        w.gen_value = '1;
        send_word(w);
        w = make_word(ACT_GEN_NOTE, 4'd2, 64'd0);
        w.gen_value = 32'h5;
        send_word(w);
        send_word(make_word(ACT_EVICT, 4'd2, 64'd7));
        send_word(make_word(ACT_DIRTY, 4'd2, 64'd7));
        repeat (3) send_word(make_word(ACT_SKIP, 4'd2, '1));
        w = make_word(ACT_QUERY, 4'd2, '1);
        send_word(w);
        w = make_word(ACT_COMPLETE, 4'd2, '1);
        w.gen_value = 32'h5;
        w.epoch_digest = '1;
        w.key_tag = '1;
        send_word(w);
        w.action = ACT_QUERY;
        send_word(w);
        send_word(make_word(ACT_LIST, 4'd2, 64'd0));
        w.action = ACT_DIRTY;
        send_word(w);
        w.action = ACT_QUERY;
        send_word(w);
        w.action = ACT_EVICT;
        w.key_tag = 64'd1;
        send_word(w);
        w.key_tag = '1;
        send_word(w);
        for (int k = 0; k < 8; k++)
        begin
            w = make_word(ACT_TRANSITION, 4'd3, 64'h8000_0000_0000_0000);
            w.transition_kind = 3'(k);
            w.outcome = 2'(k % 4);
            send_word(w);
            w.action = ACT_QUERY;
            send_word(w);
        end
        for (int k = int'(ACT_LIST) + 1; k < 16; k++)
            send_word(make_word(4'(k), 4'd2, 64'd0));
        send_word(make_word(ACT_RESET_OWNER, 4'd2, 64'd0));
        send_word(make_word(ACT_QUERY, 4'd2, '1));
        drain();
    endtask

    task automatic test_table_full();
        for (int k = 0; k <= ENTRIES; k++)
            send_word(make_word(ACT_SKIP, 4'd1, 64'(k)));
        send_word(make_word(ACT_COMPLETE, 4'd4, 64'd9));
        send_word(make_word(ACT_LIST, 4'd1, 64'd0));
        send_word(make_word(ACT_RESET_OWNER, 4'd1, 64'd0));
        send_word(make_word(ACT_COMPLETE, 4'd4, 64'd9));
        drain();
    endtask

    task automatic test_counter_limits();
        in_word_t w;
        repeat (256) send_word(make_word(ACT_SKIP, 4'd5, 64'd11));
        send_word(make_word(ACT_QUERY, 4'd5, 64'd11));
        w = make_word(ACT_TRANSITION, 4'd5, 64'd12);
        w.transition_kind = KIND_RUNNING;
        repeat (2) send_word(w);
        w.transition_kind = KIND_FINISHED;
        w.outcome = OUTC_DECLINED;
        send_word(w);
        w.action = ACT_QUERY;
        send_word(w);
        w = make_word(ACT_TRANSITION, 4'd5, 64'd13);
        w.transition_kind = KIND_STALE;
        send_word(w);
        w.transition_kind = KIND_FINISHED;
        send_word(w);
        send_word(make_word(ACT_GEN_NOTE, 4'd5, 64'd0));
        send_word(make_word(ACT_QUERY, 4'd5, 64'd11));
        send_word(make_word(ACT_RESET_OWNER, 4'd5, 64'd0));
        drain();
    endtask

    function automatic in_word_t random_word();
        in_word_t w;
        int p;
        w.owner_id = ($urandom_range(99) < 80) ? 4'($urandom_range(0, 3)) : 4'($urandom);
        w.time_bits = ($urandom_range(99) < 85) ? time_pool[$urandom_range(0, 5)]
                                                : {$urandom, $urandom};
        w.gen_value = ($urandom_range(99) < 80) ? gen_pool[$urandom_range(0, 1)] : $urandom;
        w.epoch_digest = ($urandom_range(99) < 80) ? digest_pool[$urandom_range(0, 2)]
                                                   : {$urandom, $urandom};
        w.key_tag = ($urandom_range(99) < 75) ? tag_pool[$urandom_range(0, 2)]
                                              : {$urandom, $urandom};
        w.transition_kind = 3'($urandom_range(0, 7));
        w.outcome = 2'($urandom_range(0, 3));
        p = $urandom_range(99);
        if (p < 3)       w.action = ACT_RESET_OWNER;
        else if (p < 10) w.action = ACT_GEN_NOTE;
        else if (p < 18) w.action = ACT_SKIP;
        else if (p < 28) w.action = ACT_COMPLETE;
        else if (p < 35) w.action = ACT_EVICT;
        else if (p < 42) w.action = ACT_DIRTY;
        else if (p < 60) w.action = ACT_TRANSITION;
        else if (p < 80) w.action = ACT_QUERY;
        else if (p < 85) w.action = ACT_READ_GEN;
        else if (p < 97) w.action = ACT_LIST;
        else             w.action = 4'($urandom_range(int'(ACT_LIST) + 1, 15));
        return w;
    endfunction

    task automatic test_random(int words);
        in_word_t w;
        int sent;
        sent = 0;
        while (sent < words)
        begin
            calm = (sent > words / 3 && sent < words / 2);
            w = random_word();
            if ($urandom_range(99) < 60)
            begin
                // A warm cycle of one frame: queued, running, finished, then completed
                // or skipped, and looked up, sometimes under the owner's noted generation.
                w.action = ACT_TRANSITION;
                w.transition_kind = KIND_QUEUED;
                send_word(w);
                w.transition_kind = KIND_RUNNING;
                send_word(w);
                w.transition_kind = KIND_FINISHED;
                w.outcome = 2'($urandom_range(0, 3));
                send_word(w);
                w.action = ($urandom_range(99) < 70) ? ACT_COMPLETE : ACT_SKIP;
                send_word(w);
                if ($urandom_range(99) < 50)
                    w.gen_value = noted_gen[w.owner_id];
                w.action = ACT_QUERY;
                send_word(w);
                sent += 5;
            end
            else
            begin
                send_word(w);
                sent++;
            end
        end
        calm = 1'b0;
        drain();
    endtask

    initial
    begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < ENTRIES; i++) rec_used[i] = 1'b0;
        for (int i = 0; i < OWNERS; i++) noted_gen[i] = '0;
        for (int i = 0; i < 6; i++) time_pool[i] = {$urandom, $urandom};
        for (int i = 0; i < 3; i++)
        begin
            digest_pool[i] = {$urandom, $urandom};
            tag_pool[i] = {$urandom, $urandom};
        end
        gen_pool[0] = $urandom;
        gen_pool[1] = $urandom;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_table_full();
        write_threshold(8'd255);
        test_counter_limits();
        write_threshold(8'd1);
        test_random(45);
        write_threshold(8'($urandom_range(2, 254)));
        test_random(45);
        write_threshold(8'd3);
        test_random(45);
        if (errors == 0 && expected_words.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/wfst_pkg.sv
hw/rtl/wfst_cell.sv
hw/rtl/warm_frame_state_table_unit.sv
bench/testbench.sv
